FILE: rtl/url_percent_decoder_core_defines.svh
// Assertion macros used by the checker file of the percent decoder.
// Depends on nothing; included by name where assertions are written.
`ifndef URL_PERCENT_DECODER_CORE_DEFINES_SVH
`define URL_PERCENT_DECODER_CORE_DEFINES_SVH

// Consequent must hold in the next cycle.
`define URLPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the same cycle.
`define URLPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/urlpd_pkg.sv
// Shared types and constants of the URL percent decoder.
// No dependencies.
`default_nettype none

package urlpd_pkg;

   localparam int MaxOut = 3;
   localparam int CntW   = $clog2(MaxOut + 1);

   localparam logic [7:0] ChPlus    = 8'h2B;
   localparam logic [7:0] ChPercent = 8'h25;
   localparam logic [7:0] ChSpace   = 8'h20;

   // escape phase: nothing pending, '%' seen, '%' and one digit seen
   typedef enum logic [2:0] {
      PhIdle = 3'b001,
      PhPct  = 3'b010,
      PhDig  = 3'b100
   } phase_type;

   // decoded bytes of one item, slot 0 goes out first
   typedef struct packed {
      logic [MaxOut-1:0][7:0] bytes;
      logic [CntW-1:0]        cnt;
      logic                   last;
   } list_type;

endpackage

`default_nettype wire

FILE: rtl/urlpd_if.sv
// Valid/ready channel interfaces for the decoder's input and result items.
// No dependencies.
`default_nettype none

interface urlpd_in_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urlpd_out_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/url_percent_decoder_core.sv
// URL percent decoder. An accepted item is held in the list register; its first byte
// moves to the output register once that register is free or its byte is being taken.
// Throughput: one item per cycle while each item yields at most one byte and rsp takes
// every byte; an item yielding two or three bytes holds req_ready low while the
// single output register drains them, one byte per cycle unless rsp stalls.
// Reset (synchronous): no escape pending, form mode off, both channels empty.
`default_nettype none

module url_percent_decoder_core
   import urlpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   urlpd_in_if.sink    req,
   urlpd_out_if.source rsp,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   // escape state: the phase and the first hex digit of a pending escape
   phase_type  phase_ff;
   phase_type  phase_in;
   logic [7:0] held_ff;   // only read in PhDig, which is entered by writing it
   logic [7:0] held_in;
   logic       plus_ff;   // form mode: '+' decodes to a space

   list_type   list;
   logic       accept;
   logic       load_ok;

   assign req.ready = load_ok;
   assign accept    = req.valid && load_ok;

   // all decoding of one item happens here, in a single pass
   urlpd_step u_step (
      .phase         (phase_ff),
      .held          (held_ff),
      .in_byte       (req.in_byte),
      .in_last       (req.in_last),
      .plus_as_space (plus_ff),
      .list          (list),
      .phase_next    (phase_in),
      .held_next     (held_in)
   );

   // control register; the user must write it only while the block is idle (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         plus_ff <= 1'b0;
      end else if (csr_wr_en) begin
         plus_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   // the list register takes a new item while the last byte of the previous
   // one moves to the output register, so single-byte items stream
   urlpd_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .list      (list),
      .load_ok   (load_ok),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_byte  (rsp.out_byte),
      .out_last  (rsp.out_last)
   );

endmodule

`default_nettype wire

FILE: rtl/urlpd_step.sv
// Per-item decode logic: from escape state and one raw byte, the output list.
// Depends on urlpd_pkg.
`default_nettype none

module urlpd_step
   import urlpd_pkg::*;
(
   input  phase_type  phase,
   input  logic [7:0] held,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       plus_as_space,
   output list_type   list,
   output phase_type  phase_next,
   output logic [7:0] held_next
);

   function automatic logic is_hex(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
   endfunction

   function automatic logic [3:0] nibble(input logic [7:0] b);
      logic [7:0] v;
      if (b <= 8'h39) v = b - 8'h30;
      else if (b <= 8'h46) v = b - 8'h37;
      else v = b - 8'h57;
      return v[3:0];
   endfunction

   logic       hv;
   logic       idle_pct;
   logic [7:0] idle_val;

   assign hv       = is_hex(in_byte);
   assign idle_pct = (in_byte == ChPercent);
   assign idle_val = (plus_as_space && in_byte == ChPlus) ? ChSpace : in_byte;

   always_comb begin
      logic do_idle;
      list       = '0;
      phase_next = PhIdle;
      held_next  = held;
      do_idle    = 1'b0;
      case (phase)
         PhPct: begin
            if (hv) begin
               phase_next = PhDig;
               held_next  = in_byte;
            end else begin
               list.bytes[list.cnt] = ChPercent;
               list.cnt = list.cnt + 1'b1;
               do_idle = 1'b1;
            end
         end
         PhDig: begin
            if (hv) begin
               list.bytes[list.cnt] = {nibble(held), nibble(in_byte)};
               list.cnt = list.cnt + 1'b1;
            end else begin
               list.bytes[list.cnt] = ChPercent;
               list.cnt = list.cnt + 1'b1;
               list.bytes[list.cnt] = held;
               list.cnt = list.cnt + 1'b1;
               do_idle = 1'b1;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      if (do_idle) begin
         if (idle_pct) begin
            phase_next = PhPct;
         end else begin
            list.bytes[list.cnt] = idle_val;
            list.cnt = list.cnt + 1'b1;
         end
      end

      // end of string: flush a pending escape literally
      if (in_last) begin
         case (phase_next)
            PhPct: begin
               list.bytes[list.cnt] = ChPercent;
               list.cnt = list.cnt + 1'b1;
            end
            PhDig: begin
               list.bytes[list.cnt] = ChPercent;
               list.cnt = list.cnt + 1'b1;
               list.bytes[list.cnt] = held_next;
               list.cnt = list.cnt + 1'b1;
            end
            default: ;
         endcase
         phase_next = PhIdle;
      end
      list.last = in_last;
   end

endmodule

`default_nettype wire

FILE: rtl/urlpd_buf.sv
// List register and output register: drains up to three bytes per item.
// Depends on urlpd_pkg.
`default_nettype none

module urlpd_buf
   import urlpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  list_type   list,
   output logic       load_ok,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [MaxOut-1:0][7:0] data_ff;
   logic [CntW-1:0]        rem_ff, rem_in;
   logic [CntW-1:0]        rd_ff, rd_in;
   logic                   last_ff;
   logic                   vld_ff, vld_in;
   logic [7:0]             byte_ff;
   logic                   olast_ff;
   logic                   pop;

   assign pop     = (rem_ff != '0) && (!vld_ff || out_ready);
   assign load_ok = (rem_ff == '0) || (rem_ff == CntW'(1) && pop);

   always_comb begin
      rem_in = rem_ff;
      rd_in  = rd_ff;
      vld_in = vld_ff && !out_ready;
      if (pop) begin
         rem_in = rem_ff - 1'b1;
         rd_in  = rd_ff + 1'b1;
         vld_in = 1'b1;
      end
      if (load) begin
         rem_in = list.cnt;
         rd_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         rd_ff  <= '0;
         vld_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         rd_ff  <= rd_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= list.bytes;
         last_ff <= list.last;
      end
      if (pop) begin
         byte_ff  <= data_ff[rd_ff];
         olast_ff <= last_ff && (rem_ff == CntW'(1));
      end
   end

   assign out_valid = vld_ff;
   assign out_byte  = byte_ff;
   assign out_last  = olast_ff;

endmodule

`default_nettype wire

FILE: rtl/urlpd_checker.sv
// Port-level checks on the percent decoder, bound to the top level.
// Depends on url_percent_decoder_core_defines.svh.
`default_nettype none
`include "url_percent_decoder_core_defines.svh"

module urlpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // a stalled result stays offered
   `URLPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // and its payload does not change
   `URLPD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_byte) && $stable(rsp_out_last))

   // back-pressure on input only while bytes are queued, so output is busy next
   `URLPD_ASSERT_NEXT(a_busy_drains, clock, reset, !req_ready, rsp_valid)

   // with the output idle, and neither rsp_valid nor req_valid set at the past sample, input is ready
   `URLPD_ASSERT_NOW(a_empty_ready, clock, reset, !rsp_valid && !$past(rsp_valid) && !$past(req_valid), req_ready)

endmodule

bind url_percent_decoder_core urlpd_checker u_urlpd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_out_byte (rsp.out_byte),
   .rsp_out_last (rsp.out_last)
);

`default_nettype wire
